### sv/swer_pkg.sv
// Shared types and constants for the sliding-window exponent recoder.
package swer_pkg;

  // Width of the window_bits register and its value after reset
  localparam int unsigned WB_W = 3;
  localparam logic [WB_W-1:0] WB_RESET = 3'd5;

  // Width of the odd-power table index on the result channel
  localparam int unsigned IDX_W = 4;

  // Result operation codes
  localparam logic OP_SQUARE   = 1'b0;
  localparam logic OP_MULTIPLY = 1'b1;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // input request taken: update window, load op plan
    logic step;   // result request taken: move to next op
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_ops;  // the offered bit causes at least one operation
    logic last;     // current operation is the last of its plan
  } status_t;

endpackage

### sv/swer_if.sv
// Channel interfaces: exponent bit input, operation output, configuration write.
interface swer_in_if;
  logic valid;
  logic ready;
  logic exp_bit;
  logic final_bit;

  modport source (output valid, output exp_bit, output final_bit, input ready);
  modport sink   (input valid, input exp_bit, input final_bit, output ready);
endinterface

interface swer_out_if;
  logic       valid;
  logic       ready;
  logic       op_kind;
  logic [3:0] table_index;
  logic       last_op;

  modport source (output valid, output op_kind, output table_index, output last_op,
                  input ready);
  modport sink   (input valid, input op_kind, input table_index, input last_op,
                  output ready);
endinterface

interface swer_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/swer_ctrl.sv
// Controller: takes one exponent bit, then hands out its operations one by one.
module swer_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  swer_pkg::status_t status,
  output swer_pkg::cmd_t    cmd
);
  import swer_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshakes and sequencing
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.has_ops) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.step = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/swer_dp.sv
// Datapath: window state, op plan registers and the result fields.
module swer_dp #(
  parameter int unsigned MAX_WINDOW = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  swer_pkg::cmd_t             cmd,
  input  logic                       exp_bit,
  input  logic                       final_bit,
  input  logic                       cfg_we,
  input  logic [swer_pkg::WB_W-1:0]  cfg_data,
  output logic                       op_kind,
  output logic [swer_pkg::IDX_W-1:0] table_index,
  output logic                       last_op,
  output swer_pkg::status_t          status
);
  import swer_pkg::*;

  // counts reach at most MAX_WINDOW + 1 (operations of a full window)
  localparam int unsigned CW = $clog2(MAX_WINDOW + 2);
  localparam int unsigned VW = MAX_WINDOW;

  logic [WB_W-1:0] window_bits_r;
  logic [CW-1:0]   count_r, sb_r, tz_r;
  logic [VW-1:0]   value_r;

  // op plan for the bit being worked off
  logic [CW-1:0]    k_r, total_r, pos_r;
  logic             mul_r;
  logic [IDX_W-1:0] idx_r;

  logic [WB_W-1:0]       w_eff;
  logic                  open_c, flush_c;
  logic [CW-1:0]         cnt_a, sb_a, tz_a;
  logic [VW:0]           val_sh;
  logic [VW-1:0]         val_a;
  logic [IDX_W+VW-1:0]   idx_wide;
  logic [CW:0]           shamt;
  logic [CW-1:0]         k_c, l_c, total_c;
  logic                  mul_c;

  // Width in force: zero acts as one, too large is clamped
  always_comb begin
    if (window_bits_r == '0) begin
      w_eff = WB_W'(1);
    end else if (window_bits_r > WB_W'(MAX_WINDOW)) begin
      w_eff = WB_W'(MAX_WINDOW);
    end else begin
      w_eff = window_bits_r;
    end
  end

  // Window update for the offered bit
  always_comb begin
    open_c = (count_r != '0) || exp_bit;
    cnt_a  = count_r + CW'(1);
    val_sh = {value_r, exp_bit};
    val_a  = val_sh[VW-1:0];
    if (exp_bit) begin
      sb_a = sb_r + tz_r + CW'(1);
      tz_a = '0;
    end else begin
      sb_a = sb_r;
      tz_a = tz_r + CW'(1);
    end
    flush_c = open_c && ((cnt_a >= CW'(w_eff)) || final_bit);
  end

  // Op plan: a zero outside a window is one plain squaring
  always_comb begin
    shamt    = {1'b0, tz_a} + (CW+1)'(1);
    idx_wide = {{IDX_W{1'b0}}, val_a} >> shamt;
    if (!open_c) begin
      k_c   = CW'(1);
      mul_c = 1'b0;
      l_c   = '0;
    end else if (flush_c) begin
      k_c   = sb_a;
      mul_c = (val_a != '0);
      l_c   = tz_a;
    end else begin
      k_c   = '0;
      mul_c = 1'b0;
      l_c   = '0;
    end
    total_c = k_c + CW'(mul_c) + l_c;
  end

  // Configuration and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_bits_r <= WB_RESET;
      count_r       <= '0;
      value_r       <= '0;
      sb_r          <= '0;
      tz_r          <= '0;
    end else begin
      if (cfg_we) begin
        window_bits_r <= cfg_data;
      end
      if (cmd.load && open_c) begin
        if (flush_c) begin
          count_r <= '0;
          value_r <= '0;
          sb_r    <= '0;
          tz_r    <= '0;
        end else begin
          count_r <= cnt_a;
          value_r <= val_a;
          sb_r    <= sb_a;
          tz_r    <= tz_a;
        end
      end
    end
  end

  // Plan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r     <= k_c;
      mul_r   <= mul_c;
      idx_r   <= idx_wide[IDX_W-1:0];
      total_r <= total_c;
      pos_r   <= '0;
    end else if (cmd.step) begin
      pos_r <= pos_r + CW'(1);
    end
  end

  // Result fields: squarings, the multiply after k of them, then the rest
  always_comb begin
    op_kind     = (mul_r && (pos_r == k_r)) ? OP_MULTIPLY : OP_SQUARE;
    table_index = (op_kind == OP_MULTIPLY) ? idx_r : '0;
    last_op     = (pos_r == total_r - CW'(1));
  end

  assign status.has_ops = (total_c != '0);
  assign status.last    = last_op;

endmodule

### sv/sliding_window_exponent_recoder_unit.sv
// Top level of the sliding-window exponent recoder.
// Exponent bits enter most significant first, from the top set bit; each bit
// yields the squarings and table multiplies of sliding-window exponentiation,
// with last_op marking the final operation that the bit causes. A bit that
// only extends an open window yields no operation. A bit is taken, then its n
// operations are offered one per cycle while the sink is ready; a flush yields
// up to MAX_WINDOW + 1 operations, since a window that was opened under a
// wider setting may hold up to MAX_WINDOW bits. The datapath holds one bit's
// operation plan at a time in its plan registers, so the next bit is taken
// only after the last operation of the current one. The window_bits register is
// written over the cfg channel; the user must write it only while no request is
// outstanding, which the block itself does not enforce. It resets to 5, 0 acts
// as 1 and values above MAX_WINDOW act as MAX_WINDOW.
module sliding_window_exponent_recoder_unit #(
  parameter int unsigned MAX_WINDOW = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  swer_in_if.sink    in_ch,
  swer_out_if.source out_ch,
  swer_cfg_if.sink   cfg_ch
);
  import swer_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  swer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  swer_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .exp_bit     (in_ch.exp_bit),
    .final_bit   (in_ch.final_bit),
    .cfg_we      (cfg_ch.valid),
    .cfg_data    (cfg_ch.data),
    .op_kind     (out_ch.op_kind),
    .table_index (out_ch.table_index),
    .last_op     (out_ch.last_op),
    .status      (status)
  );

endmodule

### test/sliding_window_exponent_recoder_unit_tb.sv
// Testbench for the sliding-window exponent recoder: directed table, then random bit streams.
module sliding_window_exponent_recoder_unit_tb;
  import swer_pkg::*;

  localparam int unsigned WIN_MAX       = 5;
  localparam int          IDLE_LIMIT    = 3000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          NO_WRITE      = -1;
  localparam int          MAX_SHOWN     = 10;

  typedef struct packed {
    logic             op_kind;
    logic [IDX_W-1:0] table_index;
    logic             last_op;
  } op_t;

  // One bit request; the operations it causes are typed in where they are obvious
  typedef struct packed {
    int               wb;         // window_bits written first, NO_WRITE for none
    logic             exp_bit;
    logic             final_bit;
    logic             typed;
    int               sq_pre;     // squarings before the multiply
    logic             has_mul;
    logic [IDX_W-1:0] mul_idx;
    int               sq_post;    // squarings after the multiply
  } bit_req_t;

  logic clk = 1'b0;
  logic rst_n;

  swer_in_if  in_if ();
  swer_out_if out_if ();
  swer_cfg_if cfg_if ();

  sliding_window_exponent_recoder_unit #(
    .MAX_WINDOW(WIN_MAX)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #5 clk = ~clk;

  // Recoder state as predicted
  logic [WB_W-1:0] win_bits_q;
  logic [2:0]      win_count_q;
  logic [4:0]      win_value_q;
  logic [2:0]      sq_before_q;
  logic [2:0]      tz_q;

  op_t      due_ops[$];   // operations still to arrive, oldest first
  op_t      bit_ops[$];   // operations caused by the bit being predicted
  bit_req_t dir_reqs[$];
  bit_req_t cur_req;

  int   mismatches    = 0;
  int   ops_checked   = 0;
  int   bits_sent     = 0;
  int   cfg_writes    = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   exp_left      = 0;
  int   quiet_cycles  = 0;
  logic rx_hold       = 1'b0;

  function automatic bit_req_t mk_req(input int wb, input logic b, input logic fin,
                                      input logic typed, input int sq_pre,
                                      input logic has_mul, input int mul_idx,
                                      input int sq_post);
    bit_req_t r;
    r.wb        = wb;
    r.exp_bit   = b;
    r.final_bit = fin;
    r.typed     = typed;
    r.sq_pre    = sq_pre;
    r.has_mul   = has_mul;
    r.mul_idx   = IDX_W'(mul_idx);
    r.sq_post   = sq_post;
    return r;
  endfunction

  task automatic push_op(input logic kind, input logic [IDX_W-1:0] idx);
    op_t o;
    o.op_kind     = kind;
    o.table_index = idx;
    o.last_op     = 1'b0;
    bit_ops.push_back(o);
  endtask

  // Emit k squarings, the multiply, l squarings, then close the window
  task automatic flush_window();
    logic [4:0] stripped;
    for (int m = 0; m < int'(sq_before_q); m++) push_op(OP_SQUARE, '0);
    if (win_value_q != '0) begin
      stripped = win_value_q >> (tz_q + 3'd1);
      push_op(OP_MULTIPLY, stripped[IDX_W-1:0]);
    end
    for (int m = 0; m < int'(tz_q); m++) push_op(OP_SQUARE, '0);
    win_count_q = '0;
    win_value_q = '0;
    sq_before_q = '0;
    tz_q        = '0;
  endtask

  task automatic recode_bit(input logic b, input logic fin);
    logic [WB_W-1:0] w;
    w = win_bits_q;
    // zero acts as one, anything wider than the hardware acts as its maximum
    if (w == '0) w = WB_W'(1);
    if (w > WIN_MAX) w = WB_W'(WIN_MAX);
    bit_ops.delete();
    if (win_count_q == '0 && !b) begin
      push_op(OP_SQUARE, '0);
    end else begin
      win_count_q = win_count_q + 3'd1;
      win_value_q = {win_value_q[3:0], b};
      if (b) begin
        sq_before_q = sq_before_q + tz_q + 3'd1;
        tz_q        = '0;
      end else begin
        tz_q = tz_q + 3'd1;
      end
      // >= so that a width lowered mid-window flushes at once
      if (win_count_q >= w) flush_window();
    end
    if (fin && win_count_q != '0) flush_window();
  endtask

  task automatic typed_ops(input bit_req_t r);
    bit_ops.delete();
    repeat (r.sq_pre) push_op(OP_SQUARE, '0);
    if (r.has_mul) push_op(OP_MULTIPLY, r.mul_idx);
    repeat (r.sq_post) push_op(OP_SQUARE, '0);
  endtask

  // Scoreboard: predict on each bit request, check each operation request
  always @(posedge clk) begin
    op_t got;
    op_t want;
    if (!rst_n) begin
      win_bits_q  = WB_RESET;
      win_count_q = '0;
      win_value_q = '0;
      sq_before_q = '0;
      tz_q        = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) win_bits_q = cfg_if.data;
      if (in_if.valid && in_if.ready) begin
        recode_bit(in_if.exp_bit, in_if.final_bit);
        if (cur_req.typed) typed_ops(cur_req);
        if (bit_ops.size() != 0) bit_ops[bit_ops.size()-1].last_op = 1'b1;
        foreach (bit_ops[j]) due_ops.push_back(bit_ops[j]);
      end
      if (out_if.valid && out_if.ready) begin
        got.op_kind     = out_if.op_kind;
        got.table_index = out_if.table_index;
        got.last_op     = out_if.last_op;
        if (due_ops.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected op: kind %0d index %0d last %0d",
                     got.op_kind, got.table_index, got.last_op);
        end else begin
          want = due_ops.pop_front();
          ops_checked++;
          if (got.op_kind !== want.op_kind || got.table_index !== want.table_index ||
              got.last_op !== want.last_op) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("op %0d wrong: expected kind %0d index %0d last %0d, got %0d %0d %0d",
                       ops_checked, want.op_kind, want.table_index, want.last_op,
                       got.op_kind, got.table_index, got.last_op);
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while rx_hold is set
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles in which no request moves
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic offer_bit(input bit_req_t r);
    in_if.valid     <= 1'b1;
    in_if.exp_bit   <= r.exp_bit;
    in_if.final_bit <= r.final_bit;
    cur_req         <= r;
    do begin
      @(posedge clk);
    end while (in_if.ready !== 1'b1);
    bits_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stop sending, wait for every due op, then let a bit that opened a window settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (due_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input int v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= WB_W'(v);
    do begin
      @(posedge clk);
    end while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Mostly whole exponents (top bit set, final flag on the last), some loose noise bits
  task automatic pick_bit(output bit_req_t r);
    r    = '0;
    r.wb = NO_WRITE;
    if (exp_left == 0 && $urandom_range(99) < 20) begin
      r.exp_bit   = 1'($urandom_range(1));
      r.final_bit = 1'($urandom_range(1));
    end else begin
      if (exp_left == 0) begin
        exp_left  = $urandom_range(12, 1);
        r.exp_bit = 1'b1;
      end else begin
        r.exp_bit = 1'($urandom_range(1));
      end
      exp_left--;
      r.final_bit = (exp_left == 0);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int wb, input int n_bits);
    bit_req_t r;
    int       cfg_at;
    drain();
    write_cfg(wb);
    send_idle_pct = idle;
    stall_pct    <= stall;
    cfg_at        = $urandom_range(n_bits - 1, 1);
    for (int i = 0; i < n_bits; i++) begin
      // a width change here may land inside an open window
      if (i == cfg_at) begin
        drain();
        write_cfg($urandom_range(7));
      end
      pick_bit(r);
      offer_bit(r);
    end
  endtask

  initial begin
    bit_req_t r;
    int       n_dir;
    in_if.valid     <= 1'b0;
    in_if.exp_bit   <= 1'b0;
    in_if.final_bit <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    cur_req         <= '0;
    rst_n           <= 1'b0;

    //                wb        bit   fin   typed  k  mul   idx l
    dir_reqs = {
      mk_req(NO_WRITE, 1'b0, 1'b0, 1'b1,  1, 1'b0, 0,  0),  // leading zero: one square
      mk_req(NO_WRITE, 1'b0, 1'b1, 1'b1,  1, 1'b0, 0,  0),  // final, no window: no flush
      mk_req(NO_WRITE, 1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b1, 1'b0, 1'b1,  5, 1'b1, 15, 0),  // all ones: top index
      mk_req(1,        1'b1, 1'b0, 1'b1,  1, 1'b1, 0,  0),  // narrowest window
      mk_req(0,        1'b1, 1'b1, 1'b1,  1, 1'b1, 0,  0),  // width 0 acts as 1
      mk_req(NO_WRITE, 1'b0, 1'b0, 1'b1,  1, 1'b0, 0,  0),
      mk_req(7,        1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),  // width 7 clamps to 5
      mk_req(NO_WRITE, 1'b0, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b0, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b0, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b0, 1'b0, 1'b1,  1, 1'b1, 0,  4),  // six ops from one bit
      mk_req(5,        1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b0, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(2,        1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),  // width lowered mid-window
      mk_req(3,        1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b0, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b1, 1'b1, 1'b1,  3, 1'b1, 2,  0),  // final fills window: one flush
      mk_req(5,        1'b1, 1'b0, 1'b0,  0, 1'b0, 0,  0),
      mk_req(NO_WRITE, 1'b1, 1'b1, 1'b1,  2, 1'b1, 1,  0)   // final flushes partial window
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling
    foreach (dir_reqs[i]) begin
      if (dir_reqs[i].wb != NO_WRITE) begin
        drain();
        write_cfg(dir_reqs[i].wb);
      end
      offer_bit(dir_reqs[i]);
    end
    n_dir = bits_sent;

    // Random streams under each idling pattern
    run_phase(0,  0,  1, 22);
    run_phase(85, 0,  5, 22);
    run_phase(0,  85, 0, 22);
    run_phase(30, 30, 7, 22);

    // Receiver holds off while the sender keeps offering, so the input backs up
    drain();
    write_cfg(2);
    send_idle_pct = 0;
    stall_pct    <= 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      for (int i = 0; i < 20; i++) begin
        pick_bit(r);
        offer_bit(r);
      end
    join

    drain();
    $display("Covered %0d exponent bits (%0d from the directed table), %0d window_bits writes,",
             bits_sent, n_dir, cfg_writes);
    $display("idling on both sides and a %0d-cycle result hold-off; %0d ops compared.",
             HOLD_CYCLES, ops_checked);
    if (mismatches == 0 && due_ops.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
